// ===== sv/pts_pkg.sv =====
`timescale 1ns / 1ps

package pts_pkg;

  // field widths of the command and result beats
  localparam int unsigned CMD_W  = 3;
  localparam int unsigned SLOT_W = 3;
  localparam int unsigned PER_W  = 8;
  localparam int unsigned CNT_W  = 16;

  // number of slots the slot field can reach
  localparam int unsigned SCAN_LIMIT = 8;

  // bits needed to step through the tick counter during division
  localparam int unsigned BIT_W = $clog2(CNT_W);

  typedef enum logic [CMD_W-1:0] {
    CMD_TICK    = 3'd0,
    CMD_CREATE  = 3'd1,
    CMD_SUSPEND = 3'd2,
    CMD_RESUME  = 3'd3,
    CMD_KILL    = 3'd4
  } cmd_e;

endpackage

// ===== sv/pts_if.sv =====
`timescale 1ns / 1ps

// command channel
interface pts_cmd_if;
  logic                         valid;
  logic                         ready;
  logic [pts_pkg::CMD_W-1:0]    command;
  logic [pts_pkg::SLOT_W-1:0]   slot;
  logic [pts_pkg::PER_W-1:0]    period;
  logic                         start_running;

  modport source (output valid, output command, output slot, output period,
                  output start_running, input ready);
  modport sink   (input valid, input command, input slot, input period,
                  input start_running, output ready);
endinterface

// result channel
interface pts_res_if;
  logic                         valid;
  logic                         ready;
  logic                         due;
  logic [pts_pkg::SLOT_W-1:0]   due_slot;
  logic                         last;

  modport source (output valid, output due, output due_slot, output last, input ready);
  modport sink   (input valid, input due, input due_slot, input last, output ready);
endinterface

// ===== sv/periodic_task_scheduler.sv =====
`timescale 1ns / 1ps

// Periodic tick scheduler with up to eight addressable task slots (slot number is also
// priority). Create, suspend, resume, kill and any other non-tick code each give one
// acknowledge beat from the S_ACK state after the command is taken. A tick command
// bumps the 16-bit wrapping counter and then walks the slots in ascending order: each
// slot is checked in S_SCAN, every registered, running slot with a nonzero period goes
// through the shared restoring divider (one quotient bit per cycle), and each due slot
// reported before the last goes out from S_EMIT. Every due slot gives one beat with due
// set, the final one marked last; if none is due a single beat with due clear and last
// set is given. Commands are taken only while the scheduler is idle and no result is
// held.
module periodic_task_scheduler #(
  parameter int unsigned NUM_SLOTS = 8
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  pts_cmd_if.sink   in_i,
  pts_res_if.source out_o
);

  // only the slots the slot field can address are kept
  localparam int unsigned NUM_USED = (NUM_SLOTS < pts_pkg::SCAN_LIMIT) ?
                                     NUM_SLOTS : pts_pkg::SCAN_LIMIT;
  localparam int unsigned IDX_W  = (NUM_USED > 1) ? $clog2(NUM_USED) : 1;
  localparam int unsigned SCAN_W = $clog2(NUM_USED + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_ACK,
    S_SCAN,
    S_DIV,
    S_EMIT,
    S_DONE
  } state_e;

  state_e                         state_q;
  logic [pts_pkg::CNT_W-1:0]      tick_count_q;
  logic [pts_pkg::PER_W-1:0]      period_q [NUM_USED];
  logic [NUM_USED-1:0]            registered_q;
  logic [NUM_USED-1:0]            running_q;
  logic [SCAN_W-1:0]              scan_q;
  logic [pts_pkg::BIT_W-1:0]      bit_q;
  logic [pts_pkg::PER_W-1:0]      rem_q;
  logic                           pend_q;
  logic [IDX_W-1:0]               pend_slot_q;
  logic                           out_valid_q;
  logic                           out_due_q;
  logic [pts_pkg::SLOT_W-1:0]     out_slot_q;
  logic                           out_last_q;

  logic                           in_beat;
  logic                           out_beat;
  logic                           slot_ok;
  logic [IDX_W-1:0]               wr_idx;
  logic [IDX_W-1:0]               scan_idx;
  logic                           scan_end;
  logic [pts_pkg::PER_W-1:0]      cur_per;
  logic                           eligible;
  logic [pts_pkg::PER_W:0]        trial;
  logic                           trial_ge;
  logic [pts_pkg::PER_W-1:0]      rem_d;
  pts_pkg::cmd_e                  cmd;

  assign in_beat  = in_i.valid && in_i.ready;
  assign out_beat = out_valid_q && out_o.ready;
  assign cmd      = pts_pkg::cmd_e'(in_i.command);

  // slot addressing for writes and for the scan
  assign slot_ok  = ({1'b0, in_i.slot} < (pts_pkg::SLOT_W + 1)'(NUM_USED));
  assign wr_idx   = IDX_W'(in_i.slot);
  assign scan_idx = scan_q[IDX_W-1:0];
  assign scan_end = (scan_q == SCAN_W'(NUM_USED));
  assign cur_per  = period_q[scan_idx];
  assign eligible = registered_q[scan_idx] && running_q[scan_idx] && (cur_per != '0);

  // one restoring division step on the tick count
  assign trial    = {rem_q, tick_count_q[bit_q]};
  assign trial_ge = (trial >= {1'b0, cur_per});
  assign rem_d    = trial_ge ? pts_pkg::PER_W'(trial - {1'b0, cur_per})
                             : pts_pkg::PER_W'(trial);

  assign in_i.ready     = (state_q == S_IDLE) && !out_valid_q;
  assign out_o.valid    = out_valid_q;
  assign out_o.due      = out_due_q;
  assign out_o.due_slot = out_slot_q;
  assign out_o.last     = out_last_q;

  // sequencer, slot table and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      tick_count_q <= '0;
      registered_q <= '0;
      running_q    <= '0;
      scan_q       <= '0;
      bit_q        <= '0;
      rem_q        <= '0;
      pend_q       <= 1'b0;
      pend_slot_q  <= '0;
      out_valid_q  <= 1'b0;
      out_due_q    <= 1'b0;
      out_slot_q   <= '0;
      out_last_q   <= 1'b0;
      for (int i = 0; i < NUM_USED; i++) begin
        period_q[i] <= '0;
      end
    end else begin
      if (out_beat) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_beat) begin
            if (cmd == pts_pkg::CMD_TICK) begin
              tick_count_q <= tick_count_q + 1'b1;
              scan_q       <= '0;
              pend_q       <= 1'b0;
              state_q      <= S_SCAN;
            end else begin
              if (slot_ok) begin
                case (cmd)
                  pts_pkg::CMD_CREATE: begin
                    period_q[wr_idx]     <= in_i.period;
                    registered_q[wr_idx] <= 1'b1;
                    running_q[wr_idx]    <= in_i.start_running;
                  end
                  pts_pkg::CMD_SUSPEND: running_q[wr_idx] <= 1'b0;
                  pts_pkg::CMD_RESUME:  running_q[wr_idx] <= 1'b1;
                  pts_pkg::CMD_KILL: begin
                    period_q[wr_idx]     <= '0;
                    registered_q[wr_idx] <= 1'b0;
                    running_q[wr_idx]    <= 1'b0;
                  end
                  default: ;
                endcase
              end
              state_q <= S_ACK;
            end
          end
        end
        // acknowledge beat for a slot command
        S_ACK: begin
          if (!out_valid_q) begin
            out_valid_q <= 1'b1;
            out_due_q   <= 1'b0;
            out_slot_q  <= '0;
            out_last_q  <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        // check the next slot, start the divider if it could be due, or end the scan after the last slot
        S_SCAN: begin
          if (scan_end) begin
            state_q <= S_DONE;
          end else if (eligible) begin
            rem_q   <= '0;
            bit_q   <= pts_pkg::BIT_W'(pts_pkg::CNT_W - 1);
            state_q <= S_DIV;
          end else begin
            scan_q <= scan_q + 1'b1;
          end
        end
        // remainder of tick count by slot period, msb first
        S_DIV: begin
          rem_q <= rem_d;
          bit_q <= bit_q - 1'b1;
          if (bit_q == '0) begin
            if (rem_d == '0) begin
              if (pend_q) begin
                state_q <= S_EMIT;
              end else begin
                pend_q      <= 1'b1;
                pend_slot_q <= scan_idx;
                scan_q      <= scan_q + 1'b1;
                state_q     <= S_SCAN;
              end
            end else begin
              scan_q  <= scan_q + 1'b1;
              state_q <= S_SCAN;
            end
          end
        end
        // a later due slot exists, so the held one is not last
        S_EMIT: begin
          if (!out_valid_q) begin
            out_valid_q <= 1'b1;
            out_due_q   <= 1'b1;
            out_slot_q  <= pts_pkg::SLOT_W'(pend_slot_q);
            out_last_q  <= 1'b0;
            pend_slot_q <= scan_idx;
            scan_q      <= scan_q + 1'b1;
            state_q     <= S_SCAN;
          end
        end
        // final beat of a tick
        S_DONE: begin
          if (!out_valid_q) begin
            out_valid_q <= 1'b1;
            out_due_q   <= pend_q;
            out_slot_q  <= pend_q ? pts_pkg::SLOT_W'(pend_slot_q) : '0;
            out_last_q  <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // the scan pointer never runs past the table
  a_scan_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    scan_q <= SCAN_W'(NUM_USED))
    else $error("scan pointer beyond slot table");

  // the tick counter moves only on an accepted tick
  a_tick_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (tick_count_q != $past(tick_count_q)) |->
      $past(in_beat && (cmd == pts_pkg::CMD_TICK)))
    else $error("tick counter changed without a tick");

  // a result that names no task ends its command and carries slot zero
  a_idle_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_due_q) |-> (out_last_q && (out_slot_q == '0)))
    else $error("non-due result not last or with a slot");

  // no new command while one is still being worked
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_beat |=> !in_i.ready)
    else $error("command taken while busy");

  // a held due slot always lies in the table
  a_pend_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |-> ({1'b0, pend_slot_q} < (IDX_W + 1)'(NUM_USED)))
    else $error("held due slot outside table");

endmodule

// ===== tb/sv/periodic_task_scheduler_tb.sv =====
`timescale 1ns / 1ps

module periodic_task_scheduler_tb;

  // command codes with no operation behind them, acknowledged only
  localparam logic [pts_pkg::CMD_W-1:0] CMD_SPARE_A = 3'd5;
  localparam logic [pts_pkg::CMD_W-1:0] CMD_SPARE_B = 3'd6;
  localparam logic [pts_pkg::CMD_W-1:0] CMD_SPARE_C = 3'd7;

  localparam int unsigned NSLOTS       = 8;
  localparam int unsigned RANDOM_ITEMS = 245;
  localparam int unsigned DRAIN_CYCLES = 200;
  localparam int unsigned CYCLE_LIMIT  = 400_000;

  typedef struct packed {
    logic                       due;
    logic [pts_pkg::SLOT_W-1:0] due_slot;
    logic                       last;
  } report_t;

  // shadow of the slot table and tick counter, plus the reports still owed
  class sched_scoreboard;
    logic [pts_pkg::CNT_W-1:0] ticks;
    logic [pts_pkg::PER_W-1:0] period_tbl[NSLOTS];
    bit                        registered[NSLOTS];
    bit                        running[NSLOTS];
    report_t                   owed_reports[$];
    int unsigned               n_errors;

    function new();
      ticks    = '0;
      n_errors = 0;
      foreach (period_tbl[i]) begin
        period_tbl[i] = '0;
        registered[i] = 1'b0;
        running[i]    = 1'b0;
      end
    endfunction

    // work out the reports that one accepted command beat will give
    function void take_command(logic [pts_pkg::CMD_W-1:0] cmd,
                               logic [pts_pkg::SLOT_W-1:0] slot,
                               logic [pts_pkg::PER_W-1:0] period, logic start_running);
      bit [NSLOTS-1:0] due_mask;
      int              last_idx;
      report_t         rep;
      if (cmd == pts_pkg::CMD_TICK) begin
        ticks    = ticks + 1'b1;
        due_mask = '0;
        last_idx = -1;
        for (int i = 0; i < NSLOTS; i++) begin
          if (registered[i] && running[i] && period_tbl[i] != '0 &&
              (ticks % period_tbl[i]) == '0) begin
            due_mask[i] = 1'b1;
            last_idx    = i;
          end
        end
        if (last_idx < 0) begin
          rep = '{due: 1'b0, due_slot: '0, last: 1'b1};
          owed_reports.push_back(rep);
        end else begin
          for (int i = 0; i < NSLOTS; i++) begin
            if (due_mask[i]) begin
              rep = '{due: 1'b1, due_slot: pts_pkg::SLOT_W'(i), last: (i == last_idx)};
              owed_reports.push_back(rep);
            end
          end
        end
        return;
      end
      case (cmd)
        pts_pkg::CMD_CREATE: begin
          period_tbl[slot] = period;
          registered[slot] = 1'b1;
          running[slot]    = start_running;
        end
        pts_pkg::CMD_SUSPEND: running[slot] = 1'b0;
        pts_pkg::CMD_RESUME:  running[slot] = 1'b1;
        pts_pkg::CMD_KILL: begin
          period_tbl[slot] = '0;
          registered[slot] = 1'b0;
          running[slot]    = 1'b0;
        end
        default: ;
      endcase
      rep = '{due: 1'b0, due_slot: '0, last: 1'b1};
      owed_reports.push_back(rep);
    endfunction

    // compare a result beat with the oldest owed report
    function void check_report(logic due, logic [pts_pkg::SLOT_W-1:0] due_slot, logic last);
      report_t exp_rep;
      if (owed_reports.size() == 0) begin
        if (n_errors < 10)
          $display("unexpected result beat: due=%0d slot=%0d last=%0d", due, due_slot, last);
        n_errors++;
        return;
      end
      exp_rep = owed_reports.pop_front();
      if (due !== exp_rep.due || due_slot !== exp_rep.due_slot || last !== exp_rep.last) begin
        if (n_errors < 10)
          $display({"mismatch at tick %0d: expected due=%0d slot=%0d last=%0d,",
                    " got due=%0d slot=%0d last=%0d"},
                   ticks, exp_rep.due, exp_rep.due_slot, exp_rep.last, due, due_slot, last);
        n_errors++;
      end
    endfunction

    function int unsigned pending();
      return owed_reports.size();
    endfunction
  endclass

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  pts_cmd_if cmd_if ();
  pts_res_if res_if ();

  sched_scoreboard sb = new();

  int unsigned cycle_cnt = 0;
  int unsigned hold_req  = 0;

  periodic_task_scheduler #(
    .NUM_SLOTS(NSLOTS)
  ) i_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (cmd_if),
    .out_o (res_if)
  );

  // clock
  always #1 clk_i = ~clk_i;

  // cycle counter and watchdog
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
  end

  initial begin
    while (cycle_cnt < CYCLE_LIMIT) @(posedge clk_i);
    $display("== FAIL ==");
    $finish;
  end

  // result side: stall windows of random depth, plus long hold-offs on request
  initial begin
    int unsigned window;
    int unsigned stall_pct;
    int unsigned hold_left;
    window    = 0;
    stall_pct = 0;
    hold_left = 0;
    res_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req > 0) begin
        hold_left = hold_req;
        hold_req  = 0;
      end
      if (window == 0) begin
        window = $urandom_range(150, 10);
        case ($urandom_range(3))
          0:       stall_pct = 0;
          1:       stall_pct = 25;
          2:       stall_pct = 50;
          default: stall_pct = 80;
        endcase
      end
      window--;
      if (hold_left > 0) begin
        res_if.ready = 1'b0;
        hold_left--;
      end else begin
        res_if.ready = ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // check every result beat taken
  always @(posedge clk_i) begin
    if (rst_ni && res_if.valid && res_if.ready) begin
      sb.check_report(res_if.due, res_if.due_slot, res_if.last);
    end
  end

  // offer one command beat and wait until it is taken; valid stays high
  task automatic send_cmd(input logic [pts_pkg::CMD_W-1:0] cmd,
                          input logic [pts_pkg::SLOT_W-1:0] slot,
                          input logic [pts_pkg::PER_W-1:0] period, input logic start_running);
    @(negedge clk_i);
    cmd_if.valid         = 1'b1;
    cmd_if.command       = cmd;
    cmd_if.slot          = slot;
    cmd_if.period        = period;
    cmd_if.start_running = start_running;
    do @(posedge clk_i); while (!cmd_if.ready);
    sb.take_command(cmd, slot, period, start_running);
  endtask

  task automatic pause_sender(input int unsigned n);
    @(negedge clk_i);
    cmd_if.valid = 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  task automatic wait_all_reported();
    pause_sender(1);
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  // mostly small periods so that ticks find due slots often
  function automatic logic [pts_pkg::PER_W-1:0] pick_period();
    int unsigned r;
    r = $urandom_range(9);
    if (r < 6) return pts_pkg::PER_W'($urandom_range(6, 1));
    if (r < 7) return '0;
    return pts_pkg::PER_W'($urandom_range(255));
  endfunction

  task automatic send_random_cmd();
    int unsigned               r;
    logic [pts_pkg::CMD_W-1:0] cmd;
    r = $urandom_range(99);
    if (r < 40)      cmd = pts_pkg::CMD_TICK;
    else if (r < 65) cmd = pts_pkg::CMD_CREATE;
    else if (r < 75) cmd = pts_pkg::CMD_SUSPEND;
    else if (r < 85) cmd = pts_pkg::CMD_RESUME;
    else if (r < 93) cmd = pts_pkg::CMD_KILL;
    else begin
      case ($urandom_range(2))
        0:       cmd = CMD_SPARE_A;
        1:       cmd = CMD_SPARE_B;
        default: cmd = CMD_SPARE_C;
      endcase
    end
    send_cmd(cmd, pts_pkg::SLOT_W'($urandom_range(7)), pick_period(),
             1'($urandom_range(1)));
  endtask

  // main sequence
  initial begin
    int unsigned sent;
    int unsigned burst;
    cmd_if.valid         = 1'b0;
    cmd_if.command       = pts_pkg::CMD_TICK;
    cmd_if.slot          = '0;
    cmd_if.period        = '0;
    cmd_if.start_running = 1'b0;

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    repeat (3) @(posedge clk_i);

    // directed: empty tick, extremes, zero period, suspended and unregistered slots
    send_cmd(pts_pkg::CMD_TICK,    3'd0, 8'd0,   1'b0);
    send_cmd(pts_pkg::CMD_CREATE,  3'd0, 8'd1,   1'b1);
    send_cmd(pts_pkg::CMD_CREATE,  3'd7, 8'd255, 1'b1);
    send_cmd(pts_pkg::CMD_CREATE,  3'd3, 8'd0,   1'b1);
    send_cmd(pts_pkg::CMD_CREATE,  3'd5, 8'd2,   1'b0);
    send_cmd(pts_pkg::CMD_TICK,    3'd7, 8'hff,  1'b1);
    send_cmd(pts_pkg::CMD_RESUME,  3'd5, 8'd0,   1'b0);
    send_cmd(pts_pkg::CMD_TICK,    3'd0, 8'd0,   1'b0);
    send_cmd(pts_pkg::CMD_TICK,    3'd0, 8'd0,   1'b0);
    send_cmd(pts_pkg::CMD_SUSPEND, 3'd0, 8'd0,   1'b0);
    send_cmd(pts_pkg::CMD_RESUME,  3'd6, 8'd0,   1'b0);
    send_cmd(pts_pkg::CMD_TICK,    3'd0, 8'd0,   1'b0);
    send_cmd(pts_pkg::CMD_KILL,    3'd5, 8'd0,   1'b0);
    send_cmd(pts_pkg::CMD_TICK,    3'd0, 8'd0,   1'b0);
    send_cmd(CMD_SPARE_A,          3'd2, 8'haa,  1'b1);
    send_cmd(CMD_SPARE_B,          3'd7, 8'h55,  1'b0);
    send_cmd(CMD_SPARE_C,          3'd0, 8'hff,  1'b1);
    send_cmd(pts_pkg::CMD_CREATE,  3'd1, 8'd1,   1'b1);
    send_cmd(pts_pkg::CMD_CREATE,  3'd2, 8'd1,   1'b1);
    send_cmd(pts_pkg::CMD_CREATE,  3'd4, 8'd1,   1'b1);
    send_cmd(pts_pkg::CMD_CREATE,  3'd6, 8'd1,   1'b0);
    send_cmd(pts_pkg::CMD_RESUME,  3'd0, 8'd0,   1'b0);
    send_cmd(pts_pkg::CMD_RESUME,  3'd6, 8'd0,   1'b0);
    send_cmd(pts_pkg::CMD_TICK,    3'd0, 8'd0,   1'b0);
    send_cmd(pts_pkg::CMD_KILL,    3'd7, 8'd0,   1'b0);

    // random bursts with gaps; one long result hold-off and one full drain
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      burst = $urandom_range(12, 1);
      repeat (burst) begin
        send_random_cmd();
        sent++;
        if (sent == 90) hold_req = 400;
        if (sent == 180) wait_all_reported();
      end
      if ($urandom_range(3) != 0) pause_sender($urandom_range(25, 1));
    end

    // drain and let any stray beat show up
    wait_all_reported();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (sb.n_errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
sv/pts_pkg.sv
sv/pts_if.sv
sv/periodic_task_scheduler.sv
tb/sv/periodic_task_scheduler_tb.sv
